// ----- rtl/ncsi_pkg.sv -----
// Shared constants, types and fixed-point helpers for the spline interpolator.
package ncsi_pkg;

  localparam int MAX_POINTS  = 8;
  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 2);
  localparam int K_W         = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W      = 31;
  localparam int ST_W        = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd6554;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_ORDER = 3'd1;
  localparam logic [ST_W-1:0] ST_MANY  = 3'd2;
  localparam logic [ST_W-1:0] ST_FEW   = 3'd3;
  localparam logic [ST_W-1:0] ST_TRUNC = 3'd4;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_HRD, OP_HST, OP_FINIT, OP_FRD, OP_FL, OP_FMU, OP_FZ, OP_FEND,
    OP_BRD, OP_BC, OP_BB1, OP_BD, OP_BB, OP_SINIT, OP_SSEG, OP_SNEXT, OP_SDT, OP_SM,
    OP_SA_C, OP_SA_B, OP_SA_Y
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             wr;
    logic             emit;
    logic             emit_err;
    logic [ST_W-1:0]  emit_st;
    logic             emit_last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic x_le_last;
    logic t_lt_xr;
  } stat_t;

  function automatic logic signed [47:0] sx48(input logic signed [31:0] v);
    return 48'(v);
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q16.16 product finish: divide by 65536 towards zero, then saturate
  function automatic logic signed [31:0] mulq_fin(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p[63] ? (p + 64'sd65535) : p;
    return sat32(adj[63:16]);
  endfunction

  // Divide by three towards zero through a reciprocal product on the magnitude
  function automatic logic signed [31:0] div3(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [63:0] rp;
    logic [31:0] q;
    mag = v[31] ? 32'(-v) : 32'(v);
    rp  = {32'h0000_0000, mag} * 64'h0000_0000_AAAA_AAAB;
    q   = {1'b0, rp[63:33]};
    return v[31] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ----- rtl/ncsi_div.sv -----
// Iterative signed divider, one quotient bit per cycle, saturating result.
module ncsi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam logic [5:0] LAST_BIT = 6'd47;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [47:0] num_q;
  logic [31:0] rem_q, den_q;
  logic        neg_q, zero_q;
  logic [32:0] sh;
  logic [33:0] diff;
  logic        ge;
  logic [47:0] num_abs;
  logic [31:0] den_abs;

  // Trial subtract of the shifted remainder
  always_comb begin
    sh      = {rem_q, num_q[47]};
    diff    = {1'b0, sh} - {2'b00, den_q};
    ge      = ~diff[33];
    num_abs = dividend_i[47] ? 48'(-dividend_i) : 48'(dividend_i);
    den_abs = divisor_i[31] ? 32'(-divisor_i) : 32'(divisor_i);
  end

  // Sequence the bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= LAST_BIT;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in quotient bits, hold the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_abs;
      den_q  <= den_abs;
      rem_q  <= '0;
      neg_q  <= dividend_i[47] ^ divisor_i[31];
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      num_q <= {num_q[46:0], ge};
      rem_q <= ge ? diff[31:0] : sh[31:0];
    end
  end

  // Apply sign and saturate
  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (num_q > 48'h0000_8000_0000) ? -32'sh8000_0000 : $signed(-num_q[31:0]);
    end else begin
      quo_o = (num_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(num_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/ncsi_ctrl.sv -----
// Controller: knot counting, solve sequencing and sample sweep control.
module ncsi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            last_point_i,
  input  ncsi_pkg::stat_t stat_i,
  output ncsi_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import ncsi_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HRD   = 5'd1;
  localparam logic [4:0] S_HW    = 5'd2;
  localparam logic [4:0] S_FINIT = 5'd3;
  localparam logic [4:0] S_FRD   = 5'd4;
  localparam logic [4:0] S_FL    = 5'd5;
  localparam logic [4:0] S_FMU   = 5'd6;
  localparam logic [4:0] S_FW1   = 5'd7;
  localparam logic [4:0] S_FW2   = 5'd8;
  localparam logic [4:0] S_BRD   = 5'd9;
  localparam logic [4:0] S_BC    = 5'd10;
  localparam logic [4:0] S_BB1   = 5'd11;
  localparam logic [4:0] S_BW1   = 5'd12;
  localparam logic [4:0] S_BW2   = 5'd13;
  localparam logic [4:0] S_SINIT = 5'd14;
  localparam logic [4:0] S_SSEG  = 5'd15;
  localparam logic [4:0] S_SCHK  = 5'd16;
  localparam logic [4:0] S_SM1   = 5'd17;
  localparam logic [4:0] S_SA1   = 5'd18;
  localparam logic [4:0] S_SM2   = 5'd19;
  localparam logic [4:0] S_SA2   = 5'd20;
  localparam logic [4:0] S_SM3   = 5'd21;
  localparam logic [4:0] S_SA3   = 5'd22;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_POINTS + 1);
  localparam logic [K_W-1:0]   K_MAX    = K_W'(MAX_SAMPLES);

  logic [4:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] n_q, n_d, cnt_q, cnt_d, cnt_new;
  logic             ord_q, ord_d, ord_new;
  logic [K_W-1:0]   k_q, k_d;
  logic             pend_q, pend_d;
  logic [ST_W-1:0]  err_st;
  logic [CNT_W-1:0] idx_w;
  cmd_t             cmd;

  assign idx_w = CNT_W'(idx_q);

  // Next state and command
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    ord_d   = ord_q;
    k_d     = k_q;
    pend_d  = pend_q;
    cnt_new = cnt_q;
    ord_new = ord_q;
    err_st  = ST_OK;
    cmd           = '0;
    cmd.op        = OP_NOP;
    cmd.idx       = idx_q;
    cmd.emit_st   = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.op  = OP_LOAD;
          cmd.idx = cnt_q[IDX_W-1:0];
          if (cnt_q < CNT_FULL) begin
            cmd.wr  = 1'b1;
            cnt_new = cnt_q + CNT_W'(1);
            ord_new = ord_q | ((cnt_q != '0) & stat_i.x_le_last);
          end else begin
            cnt_new = CNT_OVER;
          end
          cnt_d = cnt_new;
          ord_d = ord_new;
          if (last_point_i) begin
            cnt_d = '0;
            ord_d = 1'b0;
            if (cnt_new > CNT_FULL) err_st = ST_MANY;
            else if (ord_new) err_st = ST_ORDER;
            else if (cnt_new < CNT_W'(2)) err_st = ST_FEW;
            else err_st = ST_OK;
            if (err_st != ST_OK) begin
              cmd.emit      = 1'b1;
              cmd.emit_err  = 1'b1;
              cmd.emit_st   = err_st;
              cmd.emit_last = 1'b1;
            end else begin
              n_d     = cnt_new;
              idx_d   = '0;
              state_d = S_HRD;
            end
          end
        end
      end
      S_HRD: begin
        cmd.op = OP_HRD;
        if (idx_q == '0) idx_d = IDX_W'(1);
        else state_d = S_HW;
      end
      S_HW: begin
        if (stat_i.div_done) begin
          cmd.op = OP_HST;
          if (idx_w == n_q - CNT_W'(1)) begin
            state_d = S_FINIT;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_HRD;
          end
        end
      end
      S_FINIT: begin
        cmd.op  = OP_FINIT;
        cmd.idx = '0;
        if (n_q > CNT_W'(2)) begin
          idx_d   = IDX_W'(1);
          state_d = S_FRD;
        end else begin
          idx_d   = IDX_W'(n_q - CNT_W'(2));
          state_d = S_BRD;
        end
      end
      S_FRD: begin
        cmd.op  = OP_FRD;
        state_d = S_FL;
      end
      S_FL: begin
        cmd.op  = OP_FL;
        state_d = S_FMU;
      end
      S_FMU: begin
        cmd.op  = OP_FMU;
        state_d = S_FW1;
      end
      S_FW1: begin
        if (stat_i.div_done) begin
          cmd.op  = OP_FZ;
          state_d = S_FW2;
        end
      end
      S_FW2: begin
        if (stat_i.div_done) begin
          cmd.op = OP_FEND;
          if (idx_w == n_q - CNT_W'(2)) begin
            state_d = S_BRD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_FRD;
          end
        end
      end
      S_BRD: begin
        cmd.op  = OP_BRD;
        state_d = S_BC;
      end
      S_BC: begin
        cmd.op  = OP_BC;
        state_d = S_BB1;
      end
      S_BB1: begin
        cmd.op  = OP_BB1;
        state_d = S_BW1;
      end
      S_BW1: begin
        if (stat_i.div_done) begin
          cmd.op  = OP_BD;
          state_d = S_BW2;
        end
      end
      // Finish b for this segment, then step down or start sampling
      S_BW2: begin
        cmd.op = OP_BB;
        if (idx_q == '0) begin
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = S_SINIT;
        end else begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = S_BRD;
        end
      end
      S_SINIT: begin
        cmd.op  = OP_SINIT;
        cmd.idx = '0;
        idx_d   = '0;
        state_d = S_SSEG;
      end
      S_SSEG: begin
        cmd.op  = OP_SSEG;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (stat_i.t_lt_xr) begin
          if (pend_q && (k_q >= K_MAX)) begin
            cmd.emit      = 1'b1;
            cmd.emit_st   = ST_TRUNC;
            cmd.emit_last = 1'b1;
            pend_d        = 1'b0;
            state_d       = S_IDLE;
          end else begin
            cmd.op   = OP_SDT;
            cmd.emit = pend_q;
            pend_d   = 1'b0;
            state_d  = S_SM1;
          end
        end else if (idx_w == n_q - CNT_W'(2)) begin
          cmd.emit      = pend_q;
          cmd.emit_last = 1'b1;
          pend_d        = 1'b0;
          state_d       = S_IDLE;
        end else begin
          cmd.op  = OP_SNEXT;
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SSEG;
        end
      end
      S_SM1: begin
        cmd.op  = OP_SM;
        state_d = S_SA1;
      end
      S_SA1: begin
        cmd.op  = OP_SA_C;
        state_d = S_SM2;
      end
      S_SM2: begin
        cmd.op  = OP_SM;
        state_d = S_SA2;
      end
      S_SA2: begin
        cmd.op  = OP_SA_B;
        state_d = S_SM3;
      end
      S_SM3: begin
        cmd.op  = OP_SM;
        state_d = S_SA3;
      end
      S_SA3: begin
        cmd.op  = OP_SA_Y;
        pend_d  = 1'b1;
        k_d     = k_q + K_W'(1);
        state_d = S_SCHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      ord_q   <= 1'b0;
      k_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
      ord_q   <= ord_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni) k_q <= K_MAX)
    else $error("sample count beyond limit");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_OVER)
    else $error("knot count beyond limit");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending sample left in idle");
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HW) && !stat_i.div_done |=> (state_q == S_HW))
    else $error("slope wait left early");

endmodule

// ----- rtl/ncsi_dp.sv -----
// Datapath: knot and coefficient stores, multiplier, divider and result register.
module ncsi_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ncsi_pkg::cmd_t                cmd_i,
  input  logic [ncsi_pkg::STEP_W-1:0]   step_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  output ncsi_pkg::stat_t               stat_o,
  output logic signed [31:0]            sample_x_o,
  output logic signed [31:0]            sample_y_o,
  output logic [ncsi_pkg::ST_W-1:0]     status_o,
  output logic                          last_sample_o,
  output logic                          valid_o
);
  import ncsi_pkg::*;

  logic signed [31:0] kx_q  [MAX_POINTS];
  logic signed [31:0] ky_q  [MAX_POINTS];
  logic signed [31:0] hs_q  [MAX_POINTS];
  logic signed [31:0] ss_q  [MAX_POINTS];
  logic signed [31:0] mus_q [MAX_POINTS];
  logic signed [31:0] zs_q  [MAX_POINTS];
  logic signed [31:0] cbs_q [MAX_POINTS];
  logic signed [31:0] ccs_q [MAX_POINTS];
  logic signed [31:0] cds_q [MAX_POINTS];

  logic signed [31:0] last_x_q, xp_q, yp_q, hp_q, hi_q, sp_q, si_q, mu_q, z_q;
  logic signed [31:0] l_q, al_q, zn_q, c_q, cn_q, bq_q;
  logic signed [31:0] xl_q, xr_q, yl_q, segb_q, segc_q, segd_q, dt_q, acc_q;
  logic signed [31:0] pend_x_q, pend_y_q;
  logic signed [33:0] t_q;
  logic signed [63:0] p_q;

  logic               valid_q, last_q;
  logic signed [31:0] sx_q, sy_q;
  logic [ST_W-1:0]    st_q;

  logic [IDX_W-1:0]   kx_addr, idx_m1;
  logic signed [31:0] kx_rd, ky_rd, h_new, dy_new, m_fin, l_new, c_new, s2;
  logic signed [31:0] acc_new, addend, mul_a, mul_b;
  logic signed [63:0] prod;
  logic               mul_en;
  logic [STEP_W-1:0]  step_eff;

  logic               div_start, div_done;
  logic signed [47:0] div_num;
  logic signed [31:0] div_den, quo;

  // Read ports and shared arithmetic
  always_comb begin
    kx_addr  = (cmd_i.op == OP_SSEG) ? IDX_W'(cmd_i.idx + IDX_W'(1)) : cmd_i.idx;
    idx_m1   = IDX_W'(cmd_i.idx - IDX_W'(1));
    kx_rd    = kx_q[kx_addr];
    ky_rd    = ky_q[cmd_i.idx];
    h_new    = sat32(sx48(kx_rd) - sx48(xp_q));
    dy_new   = sat32(sx48(ky_rd) - sx48(yp_q));
    m_fin    = mulq_fin(p_q);
    l_new    = sat32(((sx48(hp_q) + sx48(hi_q)) <<< 1) - sx48(m_fin));
    if (l_new < 32'sd1) l_new = 32'sd1;
    c_new    = sat32(sx48(z_q) - sx48(m_fin));
    s2       = sat32(sx48(cn_q) + (sx48(c_q) <<< 1));
    step_eff = (step_i == '0) ? STEP_W'(1) : step_i;
    case (cmd_i.op)
      OP_SA_C: addend = segc_q;
      OP_SA_B: addend = segb_q;
      default: addend = yl_q;
    endcase
    acc_new  = sat32(sx48(m_fin) + sx48(addend));
  end

  // Multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_FRD: begin
        mul_a = hp_q;
        mul_b = mu_q;
      end
      OP_FL: begin
        mul_a = hp_q;
        mul_b = z_q;
      end
      OP_BRD: begin
        mul_a = mus_q[cmd_i.idx];
        mul_b = c_q;
      end
      OP_BB1: begin
        mul_a = hi_q;
        mul_b = s2;
      end
      OP_SM: begin
        mul_a = acc_q;
        mul_b = dt_q;
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = acc_q;
        mul_b  = dt_q;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Divider operand selection
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = l_q;
    case (cmd_i.op)
      OP_HRD: begin
        div_start = (cmd_i.idx != '0);
        div_num   = $signed({dy_new, 16'h0000});
        div_den   = h_new;
      end
      OP_FMU: begin
        div_num = $signed({hi_q, 16'h0000});
        div_den = l_q;
      end
      OP_FZ: begin
        div_num = $signed({zn_q, 16'h0000});
        div_den = l_q;
      end
      OP_BB1: begin
        div_num = $signed({sat32(sx48(cn_q) - sx48(c_q)), 16'h0000});
        div_den = sat32(sx48(hi_q) * 48'sd3);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ncsi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // Advance the working registers and stores
  always_ff @(posedge clk_i) begin
    if (mul_en) p_q <= prod;
    case (cmd_i.op)
      OP_LOAD: begin
        if (cmd_i.wr) begin
          kx_q[cmd_i.idx] <= point_x_i;
          ky_q[cmd_i.idx] <= point_y_i;
          last_x_q        <= point_x_i;
        end
      end
      OP_HRD: begin
        xp_q <= kx_rd;
        yp_q <= ky_rd;
        if (cmd_i.idx != '0) hs_q[idx_m1] <= h_new;
      end
      OP_HST: ss_q[idx_m1] <= quo;
      OP_FINIT: begin
        hp_q     <= hs_q[cmd_i.idx];
        sp_q     <= ss_q[cmd_i.idx];
        mu_q     <= '0;
        z_q      <= '0;
        mus_q[0] <= '0;
        zs_q[0]  <= '0;
        c_q      <= '0;
      end
      OP_FRD: begin
        hi_q <= hs_q[cmd_i.idx];
        si_q <= ss_q[cmd_i.idx];
      end
      OP_FL: begin
        l_q  <= l_new;
        al_q <= sat32((sx48(si_q) * 48'sd3) - (sx48(sp_q) * 48'sd3));
      end
      OP_FMU: zn_q <= sat32(sx48(al_q) - sx48(m_fin));
      OP_FZ: begin
        mus_q[cmd_i.idx] <= quo;
        mu_q             <= quo;
      end
      OP_FEND: begin
        zs_q[cmd_i.idx] <= quo;
        z_q             <= quo;
        hp_q            <= hi_q;
        sp_q            <= si_q;
      end
      OP_BRD: begin
        z_q  <= zs_q[cmd_i.idx];
        hi_q <= hs_q[cmd_i.idx];
        si_q <= ss_q[cmd_i.idx];
      end
      OP_BC: begin
        ccs_q[cmd_i.idx] <= c_new;
        c_q              <= c_new;
        cn_q             <= c_q;
      end
      OP_BD: begin
        cds_q[cmd_i.idx] <= quo;
        bq_q             <= m_fin;
      end
      OP_BB: cbs_q[cmd_i.idx] <= sat32(sx48(si_q) - sx48(div3(bq_q)));
      OP_SINIT: begin
        xl_q <= kx_rd;
        t_q  <= 34'(kx_rd);
      end
      OP_SSEG: begin
        xr_q   <= kx_rd;
        yl_q   <= ky_rd;
        segb_q <= cbs_q[cmd_i.idx];
        segc_q <= ccs_q[cmd_i.idx];
        segd_q <= cds_q[cmd_i.idx];
      end
      OP_SNEXT: begin
        xl_q <= xr_q;
        t_q  <= 34'(xr_q);
      end
      OP_SDT: begin
        dt_q  <= sat32(48'(t_q) - sx48(xl_q));
        acc_q <= segd_q;
      end
      OP_SA_C, OP_SA_B: acc_q <= acc_new;
      OP_SA_Y: begin
        pend_x_q <= t_q[31:0];
        pend_y_q <= acc_new;
        t_q      <= t_q + $signed({3'b000, step_eff});
      end
      default: begin
      end
    endcase
  end

  // Drive the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= cmd_i.emit;
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sx_q   <= cmd_i.emit_err ? 32'sd0 : pend_x_q;
      sy_q   <= cmd_i.emit_err ? 32'sd0 : pend_y_q;
      st_q   <= cmd_i.emit_st;
      last_q <= cmd_i.emit_last;
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.x_le_last = (point_x_i <= last_x_q);
  assign stat_o.t_lt_xr   = (t_q < 34'(xr_q));

  assign sample_x_o    = sx_q;
  assign sample_y_o    = sy_q;
  assign status_o      = st_q;
  assign last_sample_o = last_q;
  assign valid_o       = valid_q;

endmodule

// ----- rtl/natural_cubic_spline_interpolator.sv -----
// Knot points load one per cycle (start high, busy low); results leave on valid_o, no stall.
// After the last knot, busy rises: the slope pass takes n-1 divides, the forward sweep
// two divides per inner knot, the back substitution one divide per segment.
// The solve waits for each divide to finish; sampling evaluates each sample by Horner steps.
// An error status leaves in the cycle after the last knot is taken and busy stays low.
// Reset clears the controller, knot count and step register (about 0.1); stores stay undefined.
module natural_cubic_spline_interpolator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic                        last_point_i,
  output logic                        valid_o,
  output logic signed [31:0]          sample_x_o,
  output logic signed [31:0]          sample_y_o,
  output logic [ncsi_pkg::ST_W-1:0]   status_o,
  output logic                        last_sample_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ncsi_pkg::*;

  logic [STEP_W-1:0] step_q;
  cmd_t              cmd;
  stat_t             stat;

  // Write the step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      step_q <= pwdata[STEP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, step_q};

  ncsi_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .last_point_i (last_point_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .busy_o       (busy)
  );

  ncsi_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .step_i        (step_q),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .stat_o        (stat),
    .sample_x_o    (sample_x_o),
    .sample_y_o    (sample_y_o),
    .status_o      (status_o),
    .last_sample_o (last_sample_o),
    .valid_o       (valid_o)
  );

endmodule

// ----- verif/natural_cubic_spline_interpolator_test.sv -----
// Self-checking testbench for the natural cubic spline interpolator.
module natural_cubic_spline_interpolator_test;
  import ncsi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_SAMPLE_STEP = 3'd0;
  localparam int         MAX_GAP          = 18;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } knot_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [ST_W-1:0]    st;
    logic               last;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic last_point_i = 1'b0;
  logic valid_o;
  logic signed [31:0] sample_x_o;
  logic signed [31:0] sample_y_o;
  logic [ST_W-1:0] status_o;
  logic last_sample_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  natural_cubic_spline_interpolator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  knot_t   knot_queue[$];
  sample_t sample_queue[$];
  knot_t   cur_knot;
  int      gap_left = 0;
  bit      no_idle = 0;
  int      errors = 0;
  int      knots_sent = 0;
  int      samples_seen = 0;
  int      error_results = 0;
  int      runs_done = 0;

  // Predictor state
  longint  pred_step = 6554;
  longint  kx[MAX_POINTS], ky[MAX_POINTS];
  longint  cb[MAX_POINTS], cc[MAX_POINTS], cd[MAX_POINTS];
  int      knot_cnt = 0;
  bit      order_bad = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b) / 65536);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return 0;
    return clamp32((a * 65536) / b);
  endfunction

  function automatic longint gap_x(int i);
    return clamp32(kx[i+1] - kx[i]);
  endfunction

  function automatic longint seg_slope(int i);
    return qdiv(clamp32(ky[i+1] - ky[i]), gap_x(i));
  endfunction

  function automatic void push_sample(longint x, longint y, logic [ST_W-1:0] st, logic last);
    sample_t s;
    s.x = x[31:0];
    s.y = y[31:0];
    s.st = st;
    s.last = last;
    sample_queue.push_back(s);
  endfunction

  // Fit the natural spline over n stored knots
  function automatic void fit_spline(int n);
    longint mu[MAX_POINTS], z[MAX_POINTS];
    longint hp, hi, alpha, l, h, cn, c;
    mu[0] = 0;
    z[0] = 0;
    for (int i = 1; i < n - 1; i++) begin
      hp = gap_x(i - 1);
      hi = gap_x(i);
      alpha = clamp32(3 * seg_slope(i) - 3 * seg_slope(i - 1));
      l = clamp32(2 * (hp + hi) - qmul(hp, mu[i-1]));
      if (l < 1) l = 1;
      mu[i] = qdiv(hi, l);
      z[i] = qdiv(clamp32(alpha - qmul(hp, z[i-1])), l);
    end
    cc[n-1] = 0;
    for (int i = n - 2; i >= 0; i--) begin
      h = gap_x(i);
      cn = cc[i+1];
      c = clamp32(z[i] - qmul(mu[i], cn));
      cc[i] = c;
      cb[i] = clamp32(seg_slope(i) - qmul(h, clamp32(cn + 2 * c)) / 3);
      cd[i] = qdiv(clamp32(cn - c), clamp32(3 * h));
    end
  endfunction

  // Store one knot and, on the closing one, work out every sample it causes
  function automatic void predict_knot(knot_t k);
    logic [ST_W-1:0] st;
    int n, cnt;
    longint t, dt, acc, step;
    st = ST_OK;
    cnt = 0;
    if (knot_cnt < MAX_POINTS) begin
      if (knot_cnt > 0 && longint'(k.x) <= kx[knot_cnt-1]) order_bad = 1;
      kx[knot_cnt] = k.x;
      ky[knot_cnt] = k.y;
      knot_cnt++;
    end else begin
      knot_cnt = MAX_POINTS + 1;
    end
    if (!k.last) return;
    n = knot_cnt;
    if (knot_cnt > MAX_POINTS) st = ST_MANY;
    else if (order_bad) st = ST_ORDER;
    else if (n < 2) st = ST_FEW;
    knot_cnt = 0;
    order_bad = 0;
    if (st != ST_OK) begin
      push_sample(0, 0, st, 1'b1);
      return;
    end
    fit_spline(n);
    step = (pred_step == 0) ? 1 : pred_step;
    for (int i = 0; i < n - 1; i++) begin
      t = kx[i];
      while (t < kx[i+1]) begin
        if (cnt >= MAX_SAMPLES) begin
          sample_queue[$].st = ST_TRUNC;
          sample_queue[$].last = 1'b1;
          return;
        end
        dt = clamp32(t - kx[i]);
        acc = cd[i];
        acc = clamp32(qmul(acc, dt) + cc[i]);
        acc = clamp32(qmul(acc, dt) + cb[i]);
        acc = clamp32(qmul(acc, dt) + ky[i]);
        push_sample(t, acc, ST_OK, 1'b0);
        cnt++;
        t += step;
      end
    end
    sample_queue[$].last = 1'b1;
  endfunction

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Drive knots: predict on acceptance, then wait out the drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      bit fire;
      int gap;
      fire = start && !busy;
      gap = gap_left;
      if (fire) begin
        predict_knot(cur_knot);
        knots_sent++;
        gap = draw_gap();
      end
      if (fire || !start) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (knot_queue.size() > 0) begin
          cur_knot = knot_queue.pop_front();
          point_x_i <= cur_knot.x;
          point_y_i <= cur_knot.y;
          last_point_i <= cur_knot.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
      gap_left <= gap;
    end
  end

  // Check each sample against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sample_t e;
      if (sample_queue.size() == 0) begin
        $display("%0t: unexpected sample x=%0d y=%0d status=%0d last=%0b", $time,
                 sample_x_o, sample_y_o, status_o, last_sample_o);
        errors++;
      end else begin
        e = sample_queue.pop_front();
        samples_seen++;
        if (last_sample_o) runs_done++;
        if (status_o inside {ST_ORDER, ST_MANY, ST_FEW}) error_results++;
        if (sample_x_o !== e.x || sample_y_o !== e.y || status_o !== e.st ||
            last_sample_o !== e.last) begin
          $display("%0t: mismatch expected x=%0d y=%0d st=%0d last=%0b,",
                   $time, e.x, e.y, e.st, e.last);
          $display("  got x=%0d y=%0d st=%0d last=%0b",
                   sample_x_o, sample_y_o, status_o, last_sample_o);
          errors++;
        end
      end
    end
  end

  function automatic void add_knot(longint x, longint y, bit last);
    knot_t k;
    k.x = x[31:0];
    k.y = y[31:0];
    k.last = last;
    knot_queue.push_back(k);
  endfunction

  // Well-formed run with spacings mostly scaled to the step
  function automatic void add_good_run(longint step);
    int n;
    longint x, sp;
    n = $urandom_range(2, MAX_POINTS);
    x = longint'($signed($urandom_range(0, 32'h7FFF_FFFF))) - 64'sd1073741824;
    for (int i = 0; i < n; i++) begin
      add_knot(x, longint'($signed($urandom())) >>> $urandom_range(0, 16), i == n - 1);
      sp = step * $urandom_range(1, 10);
      if ($urandom_range(0, 7) == 0) sp = $urandom_range(1, 1 << 27);
      if (sp > (1 << 27)) sp = 1 << 27;
      x += sp;
    end
  endfunction

  // Noise run: full-range fields, random length, often broken
  function automatic void add_noise_run();
    int n;
    n = $urandom_range(1, MAX_POINTS + 2);
    for (int i = 0; i < n; i++)
      add_knot(longint'($signed($urandom())), longint'($signed($urandom())), i == n - 1);
  endfunction

  task automatic write_step(logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SAMPLE_STEP;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pred_step = v[30:0];
  endtask

  // Hold until every knot is taken, every sample is back and the block is idle
  task automatic drain();
    do @(negedge clk_i);
    while (knot_queue.size() != 0 || start || busy || sample_queue.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    longint steps[6];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: too few, order fault, too many, extremes, duplicate x, plain run
    add_knot(5 << 16, 1 << 16, 1);
    add_knot(3 << 16, 0, 0);
    add_knot(1 << 16, 0, 1);
    for (int i = 0; i < MAX_POINTS + 1; i++) add_knot(i << 16, i << 14, i == MAX_POINTS);
    add_knot(-64'sd2147483648, 64'sd2147483647, 0);
    add_knot(64'sd2147483647, -64'sd2147483648, 1);
    add_knot(2 << 16, 7, 0);
    add_knot(2 << 16, 9, 1);
    add_knot(0, 0, 0);
    add_knot(1 << 16, 3 << 16, 0);
    add_knot(2 << 16, -(1 << 16), 1);
    drain();

    steps[0] = 1;
    steps[1] = 64'h7FFF_FFFF;
    steps[2] = 65536;
    steps[3] = $urandom_range(1, 1 << 20);
    steps[4] = $urandom_range(1, 32'h7FFF_FFFF);
    steps[5] = 6554;
    for (int p = -1; p < 6; p++) begin
      if (p >= 0) write_step(steps[p][31:0]);
      no_idle = (p == 2);
      for (int r = 0; r < 5; r++) begin
        if ($urandom_range(0, 5) == 0) add_noise_run();
        else add_good_run(pred_step);
      end
      drain();
    end

    $display("Covered %0d knots, %0d runs, %0d samples, %0d error results, steps 1..2^31-1.",
             knots_sent, runs_done, samples_seen, error_results);
    if (errors == 0)
      $display("natural_cubic_spline_interpolator_test: clean");
    else
      $display("natural_cubic_spline_interpolator_test: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("natural_cubic_spline_interpolator_test: errors");
    $finish;
  end

endmodule

// ----- natural_cubic_spline_interpolator.f -----
rtl/ncsi_pkg.sv
rtl/ncsi_div.sv
rtl/ncsi_ctrl.sv
rtl/ncsi_dp.sv
rtl/natural_cubic_spline_interpolator.sv
verif/natural_cubic_spline_interpolator_test.sv
